// ===== hdl/wat_pkg.sv =====
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types, widths and constants of the windowed average threshold PWM.
// ----------------------------------------------------------------------------
package wat_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int REG16_W    = 16;
	localparam int SLOPE_W    = 12;
	localparam int MATCH_W    = 16;
	localparam int MUL_W      = 16;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int WINDOW_DEF = 4;

	// Q16 off-fraction at the low end of the ramp (0.9 of full scale)
	localparam logic [MUL_W-1:0] OFF_FULL_Q16 = 16'd58982;

	localparam logic [REG16_W-1:0] PERIOD_RST = 16'd5000;
	localparam logic [REG16_W-1:0] LOW_RST    = 16'd4964;
	localparam logic [REG16_W-1:0] HIGH_RST   = 16'd9927;
	localparam logic [SLOPE_W-1:0] SLOPE_RST  = 12'd1352;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PERIOD = 2'd0;
	localparam cfg_index_t REG_LOW    = 2'd1;
	localparam cfg_index_t REG_HIGH   = 2'd2;
	localparam cfg_index_t REG_SLOPE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CMP,
		ST_MUL1,
		ST_OFF,
		ST_MUL2,
		ST_MATCH,
		ST_OUT
	} wat_state_t;

endpackage

// ===== hdl/wat_sample_if.sv =====
// ----------------------------------------------------------------------------
// wat_sample_if
// Input channel: one converter sample per transfer.
// ----------------------------------------------------------------------------
interface wat_sample_if
	import wat_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== hdl/wat_result_if.sv =====
// ----------------------------------------------------------------------------
// wat_result_if
// Output channel: update flag, alarm level and PWM match count.
// ----------------------------------------------------------------------------
interface wat_result_if
	import wat_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               updated;
	logic               alarm_level;
	logic [MATCH_W-1:0] match_value;

	modport source (output valid, output updated, output alarm_level, output match_value,
		input ready);
	modport sink   (input valid, input updated, input alarm_level, input match_value,
		output ready);
endinterface

// ===== hdl/wat_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wat_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wat_cfg_if
	import wat_pkg::*;
();
	logic                  valid;
	logic                  ready;
	cfg_index_t            index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/windowed_average_threshold_pwm.sv =====
// ----------------------------------------------------------------------------
// windowed_average_threshold_pwm
// Sums a ring of the last WINDOW samples and maps the sum to an alarm level
// and a PWM match count through one shared 16x16 multiplier.
//
// Usage:
//   sample : one 12-bit converter result per transfer
//   result : exactly one result per sample (updated, alarm_level, match_value)
//   cfg    : register writes (0 period, 1 low threshold, 2 high threshold, 3 slope),
//            always ready; user must write only with no sample in flight (unenforced)
// Each sample is written into the ring at once. A result from a partial
// window is all zero and goes through ST_OUT into the output register. With a
// full window the sequencer adds one ring entry per cycle, compares, then runs two
// products through the single multiplier; in the low or high region it goes from
// the compare straight to ST_OUT. One sample is in work at a time.
// The result sits in an output register: while the receiver stalls the next
// sample is still taken and worked on; the sequencer then waits to hand its
// result over until the output register is free.
// Reset clears the ring, write position, fill count and registers to their
// reset values; no result is pending after reset.
// ----------------------------------------------------------------------------
module windowed_average_threshold_pwm
	import wat_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wat_sample_if.sink    sample,
	wat_result_if.source  result,
	wat_cfg_if.sink       cfg
);

	localparam int IDX_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);

	// configuration registers
	logic [REG16_W-1:0] period_q;
	logic [REG16_W-1:0] low_q;
	logic [REG16_W-1:0] high_q;
	logic [SLOPE_W-1:0] slope_q;

	// ring and bookkeeping
	logic [SAMPLE_W-1:0] store_q [WINDOW];
	logic [IDX_W-1:0]    wpos_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   fill_next;
	logic                window_full;

	// datapath
	wat_state_t          state_q, state_next;
	logic [IDX_W-1:0]    idx_q;
	logic [SUM_W-1:0]    acc_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MUL_W-1:0]    off_q;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [PROD_W-8-1:0] drop;
	logic [MUL_W-1:0]    sum_ext;
	logic                res_upd_q, res_alarm_q;
	logic [MATCH_W-1:0]  res_match_q;

	// output register
	logic               out_valid_q;
	logic               out_upd_q, out_alarm_q;
	logic [MATCH_W-1:0] out_match_q;

	// control strobes
	logic in_take, sum_last, is_low, is_high, out_free, load_out;

	assign cfg.ready = 1'b1;

	assign fill_next   = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + FILL_W'(1);
	assign window_full = (fill_next == FILL_W'(WINDOW));
	assign sum_ext     = MUL_W'(acc_q);
	assign is_low      = (sum_ext < low_q);
	assign is_high     = (sum_ext > high_q);
	assign sum_last    = (idx_q == IDX_W'(WINDOW - 1));
	assign out_free    = !out_valid_q || result.ready;
	assign drop        = prod_q[PROD_W-1:8];

	// shared multiplier operands
	assign mul_a = (state_q == ST_MUL2) ? period_q : sum_ext;
	assign mul_b = (state_q == ST_MUL2) ? off_q    : MUL_W'(slope_q);
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					state_next = window_full ? ST_SUM : ST_OUT;
				end
			end
			ST_SUM: begin
				if (sum_last) begin
					state_next = ST_CMP;
				end
			end
			ST_CMP: begin
				state_next = (is_low || is_high) ? ST_OUT : ST_MUL1;
			end
			ST_MUL1:  state_next = ST_OFF;
			ST_OFF:   state_next = ST_MUL2;
			ST_MUL2:  state_next = ST_MATCH;
			ST_MATCH: state_next = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		sample.ready = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: sample.ready = 1'b1;
			ST_OUT:  load_out     = out_free;
			default: begin
				sample.ready = 1'b0;
				load_out     = 1'b0;
			end
		endcase
	end

	assign in_take = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			low_q    <= LOW_RST;
			high_q   <= HIGH_RST;
			slope_q  <= SLOPE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PERIOD: period_q <= cfg.data[REG16_W-1:0];
				REG_LOW:    low_q    <= cfg.data[REG16_W-1:0];
				REG_HIGH:   high_q   <= cfg.data[REG16_W-1:0];
				REG_SLOPE:  slope_q  <= cfg.data[SLOPE_W-1:0];
				default:    ;
			endcase
		end
	end

	// ring write on each sample transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			fill_q <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				store_q[k] <= '0;
			end
		end else if (in_take) begin
			store_q[wpos_q] <= sample.sample_value;
			wpos_q <= (wpos_q == IDX_W'(WINDOW - 1)) ? '0 : wpos_q + IDX_W'(1);
			fill_q <= fill_next;
		end
	end

	// sequenced datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					idx_q       <= '0;
					acc_q       <= '0;
					res_upd_q   <= window_full;
					res_alarm_q <= 1'b0;
					res_match_q <= '0;
				end
			end
			ST_SUM: begin
				acc_q <= acc_q + SUM_W'(store_q[idx_q]);
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_CMP: begin
				// low region is tested first
				res_alarm_q <= !is_low && is_high;
			end
			ST_MUL1: prod_q <= mul_p;
			ST_OFF: begin
				// off-fraction saturates at zero
				off_q <= (drop > (PROD_W-8)'(OFF_FULL_Q16)) ? '0 : OFF_FULL_Q16 - drop[MUL_W-1:0];
			end
			ST_MUL2:  prod_q <= mul_p;
			ST_MATCH: res_match_q <= prod_q[PROD_W-1:PROD_W-MATCH_W];
			default:  ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_upd_q   <= res_upd_q;
			out_alarm_q <= res_alarm_q;
			out_match_q <= res_match_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.updated     = out_upd_q;
	assign result.alarm_level = out_alarm_q;
	assign result.match_value = out_match_q;

endmodule

// ===== hdl/wat_checker.sv =====
// ----------------------------------------------------------------------------
// wat_checker
// Port-level checks of the windowed average threshold PWM, bound to the top.
// ----------------------------------------------------------------------------
module wat_checker
	import wat_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic               updated,
	input logic               alarm_level,
	input logic [MATCH_W-1:0] match_value
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(updated) && $stable(alarm_level) && $stable(match_value))
		else $error("result changed while stalled");

	// only one sample in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while busy");

	// a result from a partial window carries nothing
	a_not_updated_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !updated |-> !alarm_level && (match_value == '0))
		else $error("non-updated result not zero");

	// high region drives no PWM match
	a_alarm_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && alarm_level |-> updated && (match_value == '0))
		else $error("alarm with nonzero match");

endmodule

bind windowed_average_threshold_pwm wat_checker u_wat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.updated      (result.updated),
	.alarm_level  (result.alarm_level),
	.match_value  (result.match_value)
);

// ===== dv/wat_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wat_result_checker
// Watches the sample, register and result channels of the windowed average
// threshold PWM. Keeps its own copy of the sample ring and the registers,
// works out the result of every sample transfer, and compares each result
// transfer with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module wat_result_checker
	import wat_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  smp_valid,
	input  logic                  smp_ready,
	input  logic [SAMPLE_W-1:0]   smp_value,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  logic                  res_updated,
	input  logic                  res_alarm,
	input  logic [MATCH_W-1:0]    res_match,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding,
	output int                    results_seen,
	output int                    reg_writes,
	output int                    filling_cnt,
	output int                    low_cnt,
	output int                    high_cnt,
	output int                    middle_cnt,
	output int                    clamp_cnt
);

	// window sum of up to 32 entries of 12 bits
	localparam int SUM_W = SAMPLE_W + 5;

	typedef struct packed {
		logic               updated;
		logic               alarm_level;
		logic [MATCH_W-1:0] match_value;
	} pwm_result_t;

	pwm_result_t pending_results[$];

	logic [SAMPLE_W-1:0] ring [WINDOW];
	int                  wr_pos;
	int                  fill;

	logic [REG16_W-1:0]  period;
	logic [REG16_W-1:0]  low_thr;
	logic [REG16_W-1:0]  high_thr;
	logic [SLOPE_W-1:0]  slope;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] result %0d %s: got %0d, expected %0d",
				$realtime, results_seen, what, got, want);
	endtask

	// advance the ring by one sample and compute the result it causes
	function automatic pwm_result_t pwm_for_sample(input logic [SAMPLE_W-1:0] value);
		pwm_result_t                res;
		logic [SUM_W-1:0]           sum;
		logic [SUM_W+SLOPE_W-1:0]   slope_prod;
		logic [SUM_W+SLOPE_W-9:0]   drop;
		logic [MUL_W-1:0]           off_q16;
		logic [PROD_W-1:0]          period_prod;
		int                         k;
		res = '0;
		ring[wr_pos] = value;
		wr_pos = (wr_pos + 1 >= WINDOW) ? 0 : wr_pos + 1;
		if (fill < WINDOW)
			fill++;
		if (fill < WINDOW) begin
			filling_cnt++;
			return res;
		end
		sum = '0;
		for (k = 0; k < WINDOW; k++)
			sum += SUM_W'(ring[k]);
		res.updated = 1'b1;
		// low test first, so an inverted threshold pair still sorts deterministically
		if (sum < low_thr) begin
			low_cnt++;
		end else if (sum > high_thr) begin
			res.alarm_level = 1'b1;
			high_cnt++;
		end else begin
			slope_prod = (SUM_W+SLOPE_W)'(sum) * (SUM_W+SLOPE_W)'(slope);
			drop = slope_prod[SUM_W+SLOPE_W-1:8];
			if (drop > (SUM_W+SLOPE_W-8)'(OFF_FULL_Q16)) begin
				off_q16 = '0;
				clamp_cnt++;
			end else begin
				off_q16 = OFF_FULL_Q16 - drop[MUL_W-1:0];
			end
			period_prod = PROD_W'(period) * PROD_W'(off_q16);
			res.match_value = period_prod[PROD_W-1:MUL_W];
			middle_cnt++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pwm_result_t oldest;
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++)
				ring[k] = '0;
			wr_pos = 0;
			fill = 0;
			period = PERIOD_RST;
			low_thr = LOW_RST;
			high_thr = HIGH_RST;
			slope = SLOPE_RST;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// results first: a result can never belong to a sample taken at this edge
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("arrived with nothing outstanding, match", res_match, 0);
				end else begin
					oldest = pending_results.pop_front();
					if (res_updated !== oldest.updated)
						report_mismatch("updated", res_updated, oldest.updated);
					if (res_alarm !== oldest.alarm_level)
						report_mismatch("alarm_level", res_alarm, oldest.alarm_level);
					if (res_match !== oldest.match_value)
						report_mismatch("match_value", res_match, oldest.match_value);
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_PERIOD: period = cfg_data;
					REG_LOW:    low_thr = cfg_data;
					REG_HIGH:   high_thr = cfg_data;
					REG_SLOPE:  slope = cfg_data[SLOPE_W-1:0];
					default: ;
				endcase
			end
			if (smp_valid && smp_ready)
				pending_results.push_back(pwm_for_sample(smp_value));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== dv/tb_windowed_average_threshold_pwm.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_average_threshold_pwm
// Drives samples and register writes into the windowed average threshold PWM
// under random sender gaps and receiver stalls. A short directed run covers
// window fill, threshold edges, off-fraction underflow, zero period and an
// inverted threshold pair; random runs follow over many register settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_windowed_average_threshold_pwm;
	import wat_pkg::*;

	localparam int WINDOW       = WINDOW_DEF;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 4 * (WINDOW + 7);
	localparam int BLOCK_ITEMS  = 105;

	logic clk;
	logic arst_n;

	wat_sample_if sample_if ();
	wat_result_if result_if ();
	wat_cfg_if    cfg_if ();

	int mismatches;
	int outstanding;
	int results_seen;
	int reg_writes;
	int filling_cnt;
	int low_cnt;
	int high_cnt;
	int middle_cnt;
	int clamp_cnt;

	int gap_pct;
	int stall_pct;
	int samples_sent;
	int drain_waits;
	int cycle_count;

	logic [REG16_W-1:0] cur_low;
	logic [REG16_W-1:0] cur_high;

	windowed_average_threshold_pwm #(
		.WINDOW(WINDOW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if.sink),
		.result (result_if.source),
		.cfg    (cfg_if.sink)
	);

	wat_result_checker #(
		.WINDOW(WINDOW)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp_valid    (sample_if.valid),
		.smp_ready    (sample_if.ready),
		.smp_value    (sample_if.sample_value),
		.res_valid    (result_if.valid),
		.res_ready    (result_if.ready),
		.res_updated  (result_if.updated),
		.res_alarm    (result_if.alarm_level),
		.res_match    (result_if.match_value),
		.cfg_valid    (cfg_if.valid),
		.cfg_ready    (cfg_if.ready),
		.cfg_index    (cfg_if.index),
		.cfg_data     (cfg_if.data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.reg_writes   (reg_writes),
		.filling_cnt  (filling_cnt),
		.low_cnt      (low_cnt),
		.high_cnt     (high_cnt),
		.middle_cnt   (middle_cnt),
		.clamp_cnt    (clamp_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		result_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outstanding);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// valid is left high after the transfer; the next call decides what follows
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < gap_pct) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
		sample_if.valid <= 1'b1;
		sample_if.sample_value <= value;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		drain_waits++;
	endtask

	task automatic write_reg(input cfg_index_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	// only called once every outstanding result has been taken
	task automatic write_config(input logic [CFG_DATA_W-1:0] period,
		input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
		input logic [CFG_DATA_W-1:0] slope_data);
		write_reg(REG_PERIOD, period);
		write_reg(REG_LOW, low);
		write_reg(REG_HIGH, high);
		write_reg(REG_SLOPE, slope_data);
		cfg_if.valid <= 1'b0;
		cur_low = low;
		cur_high = high;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] period;
		logic [CFG_DATA_W-1:0] low;
		logic [CFG_DATA_W-1:0] high;
		logic [CFG_DATA_W-1:0] slope_data;
		logic [SAMPLE_W-1:0]   value;
		int                    target;
		int                    base;
		int                    level;
		int                    mode;

		arst_n <= 1'b0;
		sample_if.valid <= 1'b0;
		sample_if.sample_value <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_PERIOD;
		cfg_if.data <= '0;
		cur_low = LOW_RST;
		cur_high = HIGH_RST;
		gap_pct = 0;
		stall_pct = 20;
		base = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window fill, a sum right on each threshold, high, low
		send_sample(12'hFFF);
		send_sample(12'h000);
		send_sample(12'hFFF);
		repeat (4) send_sample(12'd1241);
		repeat (3) send_sample(12'd2482);
		send_sample(12'd2481);
		send_sample(12'hFFF);
		repeat (3) send_sample(12'h000);

		// widest registers: off-fraction underflow on a full window, then a small sum
		wait_drained();
		write_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_sample(12'hFFF);
		repeat (4) send_sample(12'd10);

		// zero period, zero slope, low threshold above high threshold
		wait_drained();
		write_config(16'h0000, 16'd100, 16'd50, 16'h0000);
		repeat (4) send_sample(12'd25);
		send_sample(12'd0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin gap_pct = 31; stall_pct = 84; end
				1: begin gap_pct = 84; stall_pct = 31; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				wait_drained();
				period = 16'($urandom_range(65535));
				low = 16'($urandom_range(16380));
				high = low + 16'($urandom_range(8000));
				slope_data = 16'($urandom_range(65535));
				case ($urandom_range(5))
					0: period = $urandom_range(1) ? 16'd0 : 16'd1;
					1: period = 16'hFFFF;
					2: begin
						low = 16'($urandom_range(65535));
						high = 16'($urandom_range(65535));
					end
					3: slope_data = {4'($urandom_range(15)), 12'd0};
					4: begin period = PERIOD_RST; low = LOW_RST; high = HIGH_RST;
						slope_data = 16'(SLOPE_RST); end
					default: ;
				endcase
				if (blk == 3 && phase == 2)
					write_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0FFF);
				else
					write_config(period, low, high, slope_data);

				for (int i = 0; i < BLOCK_ITEMS; i++) begin
					// steer the window toward a threshold, the middle or anywhere
					if ((i % 16) == 0) begin
						case ($urandom_range(3))
							0: target = int'(cur_low);
							1: target = int'(cur_high);
							2: target = (int'(cur_low) + int'(cur_high)) / 2;
							default: target = int'($urandom_range(16380));
						endcase
						base = target / WINDOW;
						if (base > 4095)
							base = 4095;
					end
					if ($urandom_range(63) == 0)
						wait_drained();
					mode = int'($urandom_range(9));
					if (mode == 0) begin
						value = 12'($urandom_range(4095));
					end else if (mode == 1) begin
						value = $urandom_range(1) ? 12'hFFF : 12'h000;
					end else begin
						level = base + int'($urandom_range(160)) - 80;
						if (level < 0)
							level = 0;
						if (level > 4095)
							level = 4095;
						value = level[SAMPLE_W-1:0];
					end
					send_sample(value);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples, %0d register writes, %0d full drains, %0d cycles",
			samples_sent, reg_writes, drain_waits, cycle_count);
		$display("results %0d: %0d filling, %0d low, %0d high, %0d middle (%0d clamped)",
			results_seen, filling_cnt, low_cnt, high_cnt, middle_cnt, clamp_cnt);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
